[hw/rtl/stre_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_pkg
// Shared constants, types and the combine function of the range extreme tree.
// ----------------------------------------------------------------------------
package stre_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int VAL_W      = 48;
  localparam int OPC_W      = 2;
  localparam int IDX_W      = 10;
  localparam int RNG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OPC_W-1:0] OP_SET   = 2'd0;
  localparam logic [OPC_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY = 2'd1;

  localparam logic signed [VAL_W-1:0] RESET_IDENTITY = -48'sd100000000;

  typedef struct packed {
    logic load_set;
    logic set_write;
    logic set_up;
    logic load_query;
    logic q_read_l;
    logic q_read_r;
    logic q_acc;
    logic l_inc;
    logic shift;
    logic load_clear;
    logic clear_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             set_ok;
    logic             k_is_root;
    logic             l_lt_r;
    logic             l_odd;
    logic             r_odd;
    logic             sweep_last;
  } stat_t;

  function automatic logic signed [VAL_W-1:0] combine(
    input logic                    is_min,
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    if (is_min) begin
      combine = (a < b) ? a : b;
    end else begin
      combine = (a > b) ? a : b;
    end
  endfunction

endpackage

[hw/rtl/stre_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_req_if
// Request channel: opcode, leaf write fields and query bounds.
// ----------------------------------------------------------------------------
interface stre_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [stre_pkg::OPC_W-1:0]             opcode;
  logic [stre_pkg::IDX_W-1:0]             leaf_index;
  logic signed [stre_pkg::VAL_W-1:0]      leaf_value;
  logic [stre_pkg::RNG_W-1:0]             range_low;
  logic [stre_pkg::RNG_W-1:0]             range_high;

  modport source (output valid, opcode, leaf_index, leaf_value, range_low, range_high,
                  input ready);
  modport sink   (input valid, opcode, leaf_index, leaf_value, range_low, range_high,
                  output ready);
endinterface

[hw/rtl/stre_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_rsp_if
// Response channel: query result.
// ----------------------------------------------------------------------------
interface stre_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [stre_pkg::VAL_W-1:0] query_result;

  modport source (output valid, query_result, input ready);
  modport sink   (input valid, query_result, output ready);
endinterface

[hw/rtl/stre_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface stre_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [stre_pkg::CFG_IDX_W-1:0] index;
  logic [stre_pkg::VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/segment_tree_range_extreme.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_extreme
// Segment tree with range max/min query, leaf set and clear to identity.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | opcode, leaf_index, leaf_value, range_low, range_high
//  rsp     | out | valid/ready | query_result
//  cfg     | in  | valid/ready | index, data (0 combine_is_min, 1 identity_value)
//
//  One request at a time; nodes live in one single-read-port RAM.
//  Set: alternates a node write with a move up the path, one sibling read per level.
//  Query: walks up the levels, one node read per odd bound at each level.
//  Clear, and the sweep after reset: writes all 2P node addresses (2048), req.ready low meanwhile.
//  rsp holds its result in a register; while it stalls, the next query waits
//  in its last cycle and req.ready stays low behind it.
module segment_tree_range_extreme #(
  parameter int LEAVES = stre_pkg::LEAVES_DEF
) (
  input logic       clk,
  input logic       rst,
  stre_req_if.sink  req,
  stre_rsp_if.source rsp,
  stre_cfg_if.sink  cfg
);

  stre_pkg::cmd_t  cmd;
  stre_pkg::stat_t st;

  assign cfg.ready = 1'b1;

  stre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  stre_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (req.opcode),
    .leaf_index   (req.leaf_index),
    .leaf_value   (req.leaf_value),
    .range_low    (req.range_low),
    .range_high   (req.range_high),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .query_result (rsp.query_result),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

[hw/rtl/stre_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stre_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/stre_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_ctrl
// Sequencer for set, query and clear; owns request/response handshakes.
// ----------------------------------------------------------------------------
module stre_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  stre_pkg::stat_t st,
  output stre_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_WR,
    S_SET_UP,
    S_Q_TEST,
    S_Q_L,
    S_Q_R,
    S_Q_OUT
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (st.op)
            stre_pkg::OP_SET: begin
              if (st.set_ok) begin
                cmd.load_set = 1'b1;
                state_next   = S_SET_WR;
              end
            end
            stre_pkg::OP_QUERY: begin
              cmd.load_query = 1'b1;
              state_next     = S_Q_TEST;
            end
            stre_pkg::OP_CLEAR: begin
              cmd.load_clear = 1'b1;
              state_next     = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_SET_WR: begin
        cmd.set_write = 1'b1;
        state_next    = st.k_is_root ? S_IDLE : S_SET_UP;
      end
      S_SET_UP: begin
        cmd.set_up = 1'b1;
        state_next = S_SET_WR;
      end
      S_Q_TEST: begin
        priority if (!st.l_lt_r) begin
          state_next = S_Q_OUT;
        end else if (st.l_odd) begin
          cmd.q_read_l = 1'b1;
          state_next   = S_Q_L;
        end else if (st.r_odd) begin
          cmd.q_read_r = 1'b1;
          state_next   = S_Q_R;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_Q_L: begin
        cmd.q_acc = 1'b1;
        cmd.l_inc = 1'b1;
        if (st.r_odd) begin
          cmd.q_read_r = 1'b1;
          state_next   = S_Q_R;
        end else begin
          cmd.shift  = 1'b1;
          state_next = S_Q_TEST;
        end
      end
      S_Q_R: begin
        cmd.q_acc  = 1'b1;
        cmd.shift  = 1'b1;
        state_next = S_Q_TEST;
      end
      S_Q_OUT: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/stre_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_dp
// Node memory, walk pointers, accumulator and configuration registers.
// ----------------------------------------------------------------------------
module stre_dp #(
  parameter int LEAVES = stre_pkg::LEAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [stre_pkg::OPC_W-1:0]        opcode,
  input  logic [stre_pkg::IDX_W-1:0]        leaf_index,
  input  logic signed [stre_pkg::VAL_W-1:0] leaf_value,
  input  logic [stre_pkg::RNG_W-1:0]        range_low,
  input  logic [stre_pkg::RNG_W-1:0]        range_high,
  input  logic                              cfg_valid,
  input  logic [stre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stre_pkg::VAL_W-1:0]        cfg_data,
  output logic signed [stre_pkg::VAL_W-1:0] query_result,
  input  stre_pkg::cmd_t                    cmd,
  output stre_pkg::stat_t                   st
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int ADDR_W = LEVELS + 1;
  localparam int NODE_W = LEVELS + 2;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int CMP_W  = (NODE_W > stre_pkg::RNG_W) ? NODE_W : stre_pkg::RNG_W;
  localparam logic [CMP_W-1:0] PAD_C    = CMP_W'(1) << LEVELS;
  localparam logic [CMP_W-1:0] LEAVES_C = CMP_W'(LEAVES);

  logic                              combine_is_min;
  logic signed [stre_pkg::VAL_W-1:0] identity_value;
  logic signed [stre_pkg::VAL_W-1:0] fill;
  logic signed [stre_pkg::VAL_W-1:0] hold;
  logic signed [stre_pkg::VAL_W-1:0] acc;
  logic [ADDR_W-1:0]                 cnt;
  logic [ADDR_W-1:0]                 k;
  logic [NODE_W-1:0]                 l;
  logic [NODE_W-1:0]                 r;
  logic [NODE_W-1:0]                 l_next;
  logic [NODE_W-1:0]                 r_m1;

  logic [CMP_W-1:0] idx_ext, lo_ext, hi_ext, lo_sat, hi_sat;

  logic                      we, re;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [stre_pkg::VAL_W-1:0] wdata, rdata;

  assign idx_ext = CMP_W'(leaf_index);
  assign lo_ext  = CMP_W'(range_low);
  assign hi_ext  = CMP_W'(range_high);
  assign lo_sat  = (lo_ext > PAD_C) ? PAD_C : lo_ext;
  assign hi_sat  = (hi_ext > PAD_C) ? PAD_C : hi_ext;
  assign r_m1    = r - NODE_W'(1);

  assign st.op         = opcode;
  assign st.set_ok     = (idx_ext < LEAVES_C);
  assign st.k_is_root  = (k == ADDR_W'(1));
  assign st.l_lt_r     = (l < r);
  assign st.l_odd      = l[0];
  assign st.r_odd      = r[0];
  assign st.sweep_last = &cnt;

  always_comb begin
    we    = cmd.clear_step || cmd.set_write;
    waddr = cmd.clear_step ? cnt : k;
    wdata = cmd.clear_step ? fill : hold;
    re    = cmd.set_write || cmd.q_read_l || cmd.q_read_r;
    priority if (cmd.q_read_l) begin
      raddr = l[ADDR_W-1:0];
    end else if (cmd.q_read_r) begin
      raddr = r_m1[ADDR_W-1:0];
    end else begin
      raddr = k ^ ADDR_W'(1);
    end
  end

  always_comb begin
    l_next = cmd.l_inc ? (l + NODE_W'(1)) : l;
    if (cmd.shift) begin
      l_next = l_next >> 1;
    end
  end

  stre_ram #(
    .WIDTH (stre_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_is_min <= 1'b0;
      identity_value <= stre_pkg::RESET_IDENTITY;
      fill           <= stre_pkg::RESET_IDENTITY;
      cnt            <= '0;
    end else begin
      if (cfg_valid && cfg_index == stre_pkg::CFG_COMBINE) begin
        combine_is_min <= cfg_data[0];
      end
      if (cfg_valid && cfg_index == stre_pkg::CFG_IDENTITY) begin
        identity_value <= cfg_data;
      end
      if (cmd.load_clear) begin
        fill <= identity_value;
        cnt  <= '0;
      end else if (cmd.clear_step) begin
        cnt <= cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_set) begin
      k    <= ADDR_W'(PAD_C + idx_ext);
      hold <= leaf_value;
    end else if (cmd.set_up) begin
      k    <= k >> 1;
      hold <= stre_pkg::combine(combine_is_min, hold, rdata);
    end
    if (cmd.load_query) begin
      l   <= NODE_W'(lo_sat + PAD_C);
      r   <= NODE_W'(hi_sat + PAD_C);
      acc <= identity_value;
    end else begin
      l <= l_next;
      if (cmd.shift) begin
        r <= r >> 1;
      end
      if (cmd.q_acc) begin
        acc <= stre_pkg::combine(combine_is_min, acc, rdata);
      end
    end
    if (cmd.load_result) begin
      query_result <= acc;
    end
  end

endmodule

[tb/sv/stre_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stre_result_check
// Watches the request, response and register channels of the range extreme
// tree. It keeps a shadow copy of every node and of both registers, works out
// each query answer when the request is taken, and compares the answers in
// order as they leave the block.
// ----------------------------------------------------------------------------
module stre_result_check #(
  parameter int LEAVES = stre_pkg::LEAVES_DEF
) (
  input  logic clk,
  input  logic rst,
  stre_req_if  req,
  stre_rsp_if  rsp,
  stre_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);
  import stre_pkg::*;

  function automatic int pow2_ceil(input int n);
    int p;
    p = 1;
    while (p < n) p = p * 2;
    return p;
  endfunction

  localparam int SPAN = pow2_ceil(LEAVES);

  logic signed [VAL_W-1:0] shadow [1:2*SPAN-1];
  logic                    take_min;
  logic signed [VAL_W-1:0] empty_value;
  logic signed [VAL_W-1:0] want_value;
  logic signed [VAL_W-1:0] pending_extremes [$];

  function automatic logic signed [VAL_W-1:0] pick(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    if (take_min) begin
      return (b < a) ? b : a;
    end
    return (b > a) ? b : a;
  endfunction

  task automatic fill_tree(input logic signed [VAL_W-1:0] v);
    for (int k = 1; k < 2 * SPAN; k++) shadow[k] = v;
  endtask

  task automatic store_leaf(input int idx, input logic signed [VAL_W-1:0] v);
    int k;
    if (idx >= LEAVES) return;
    k = SPAN + idx;
    shadow[k] = v;
    while (k > 1) begin
      k = k / 2;
      shadow[k] = pick(shadow[2*k], shadow[2*k+1]);
    end
  endtask

  // bottom-up walk over [lo, hi), bounds clamped to the padded leaf count
  function automatic logic signed [VAL_W-1:0] extreme_over_range(input int lo, input int hi);
    logic signed [VAL_W-1:0] acc;
    int l;
    int r;
    acc = empty_value;
    l = ((lo > SPAN) ? SPAN : lo) + SPAN;
    r = ((hi > SPAN) ? SPAN : hi) + SPAN;
    while (l < r) begin
      if (l % 2 == 1) begin
        acc = pick(acc, shadow[l]);
        l++;
      end
      if (r % 2 == 1) begin
        r--;
        acc = pick(acc, shadow[r]);
      end
      l = l / 2;
      r = r / 2;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      take_min     = 1'b0;
      empty_value  = RESET_IDENTITY;
      fill_tree(RESET_IDENTITY);
      pending_extremes.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          CFG_COMBINE:  take_min = cfg.data[0];
          CFG_IDENTITY: empty_value = cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        results_seen++;
        if (pending_extremes.size() == 0) begin
          fail_count++;
          $display("%0t: query_result %0d arrived with none expected", $time,
                   rsp.query_result);
        end else begin
          want_value = pending_extremes.pop_front();
          if (rsp.query_result !== want_value) begin
            fail_count++;
            $display("%0t: query_result expected %0d, got %0d", $time, want_value,
                     rsp.query_result);
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        case (req.opcode)
          OP_SET:   store_leaf(int'(req.leaf_index), req.leaf_value);
          OP_QUERY: pending_extremes.push_back(
                      extreme_over_range(int'(req.range_low), int'(req.range_high)));
          OP_CLEAR: fill_tree(empty_value);
          default: ;
        endcase
      end
    end
    pending <= pending_extremes.size();
  end

endmodule

[tb/sv/tb_segment_tree_range_extreme.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_tree_range_extreme
// Drives leaf sets, range queries, clears and ignored opcodes into the range
// extreme tree under both combine modes and several empty values, with random
// gaps on the request side and random stalls on the response side. A checker
// beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_segment_tree_range_extreme;
  import stre_pkg::*;

  localparam int LEAVES       = LEAVES_DEF;
  localparam int RNG_MAX      = (1 << RNG_W) - 1;
  localparam int SETTLE_CYC   = 2200;   // outlasts the clear sweep
  localparam int TAIL_CYC     = 100;
  localparam int END_WAIT_MAX = 200000;
  localparam logic [OPC_W-1:0]      OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic clk;
  logic rst;
  int   tx_idle_pct = 37;
  int   rx_idle_pct = 80;
  int   fail_count;
  int   pending;
  int   results_seen;
  int   n_set, n_query, n_clear, n_ignored;

  stre_req_if req_ch ();
  stre_rsp_if rsp_ch ();
  stre_cfg_if cfg_ch ();

  segment_tree_range_extreme #(.LEAVES(LEAVES)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  stre_result_check #(.LEAVES(LEAVES)) chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [63:0] raw;
    int          s;
    raw = {$urandom, $urandom};
    s   = $urandom_range(0, 200);
    case ($urandom_range(0, 5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return VAL_W'(s - 100);
      default: return raw[VAL_W-1:0];
    endcase
  endfunction

  task automatic push_request(input logic [OPC_W-1:0] op, input int idx,
                              input logic signed [VAL_W-1:0] v, input int lo, input int hi);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.leaf_index <= IDX_W'(idx);
    req_ch.leaf_value <= v;
    req_ch.range_low  <= RNG_W'(lo);
    req_ch.range_high <= RNG_W'(hi);
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    case (op)
      OP_SET:   n_set++;
      OP_QUERY: n_query++;
      OP_CLEAR: n_clear++;
      default:  n_ignored++;
    endcase
  endtask

  // both registers back to back, valid held across the pair
  task automatic write_config(input logic use_min, input logic signed [VAL_W-1:0] ident);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_COMBINE;
    cfg_ch.data  <= VAL_W'(use_min);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.index <= CFG_IDENTITY;
    cfg_ch.data  <= ident;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic quiesce();
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic random_burst(input int count);
    int                      done;
    int                      sel;
    int                      lo;
    int                      hi;
    int                      idx;
    logic [OPC_W-1:0]        op;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 2)       op = OP_CLEAR;
      else if (sel < 5)  op = OP_UNUSED;
      else if (sel < 52) op = OP_SET;
      else               op = OP_QUERY;
      idx = ($urandom_range(0, 1) == 1) ? $urandom_range(0, LEAVES - 1) : $urandom_range(0, 31);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          lo = $urandom_range(0, LEAVES);
          hi = $urandom_range(lo, LEAVES);
        end
        5: begin
          lo = $urandom_range(0, LEAVES - 1);
          hi = lo + $urandom_range(0, 3);
        end
        6: begin
          hi = $urandom_range(0, LEAVES - 1);
          lo = $urandom_range(hi + 1, LEAVES);
        end
        7: begin
          lo = $urandom_range(0, RNG_MAX);
          hi = $urandom_range(0, RNG_MAX);
        end
        8: begin
          lo = 0;
          hi = LEAVES;
        end
        default: begin
          lo = $urandom_range(0, LEAVES);
          hi = $urandom_range(LEAVES, RNG_MAX);
        end
      endcase
      push_request(op, idx, pick_value(), lo, hi);
      if (op != OP_UNUSED) done++;
    end
  endtask

  task automatic random_phase(input int count);
    random_burst(count / 2);
    drain();
    random_burst(count - count / 2);
  endtask

  initial begin
    int i;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_SET;
    req_ch.leaf_index = '0;
    req_ch.leaf_value = '0;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_COMBINE;
    cfg_ch.data       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: max combine, default empty value
    push_request(OP_QUERY, 0, '0, 0, LEAVES);
    push_request(OP_SET, 0, VAL_MAX, 0, 0);
    push_request(OP_SET, LEAVES - 1, VAL_MIN, 0, 0);
    push_request(OP_SET, 512, '0, 0, 0);
    push_request(OP_SET, 5, -48'sd1, 0, 0);
    push_request(OP_QUERY, 0, '0, 0, LEAVES);
    push_request(OP_QUERY, 0, '0, 0, 1);
    push_request(OP_QUERY, 0, '0, LEAVES - 1, LEAVES);
    push_request(OP_QUERY, 0, '0, 1, LEAVES - 1);
    push_request(OP_QUERY, 0, '0, 5, 6);
    push_request(OP_QUERY, 0, '0, 6, 512);
    push_request(OP_QUERY, 0, '0, 7, 7);
    push_request(OP_QUERY, 0, '0, 900, 10);
    push_request(OP_QUERY, 0, '0, 1000, RNG_MAX);
    push_request(OP_QUERY, 0, '0, RNG_MAX, RNG_MAX);
    push_request(OP_QUERY, 0, '0, LEAVES, RNG_MAX);
    push_request(OP_QUERY, 0, '0, 0, RNG_MAX);
    push_request(OP_UNUSED, $urandom_range(0, LEAVES - 1), pick_value(),
                 $urandom_range(0, RNG_MAX), $urandom_range(0, RNG_MAX));
    push_request(OP_CLEAR, 0, '0, 0, 0);
    push_request(OP_QUERY, 0, '0, 0, LEAVES);
    push_request(OP_SET, LEAVES - 1, VAL_MAX, 0, 0);
    push_request(OP_SET, 0, VAL_MIN, 0, 0);
    push_request(OP_QUERY, 0, '0, 512, 2000);
    push_request(OP_QUERY, 0, '0, 0, 1);

    quiesce();
    write_config(1'b1, VAL_MAX);
    push_request(OP_CLEAR, 0, '0, 0, 0);
    random_phase(130);

    quiesce();
    tx_idle_pct = 80;
    rx_idle_pct = 37;
    write_config(1'b0, VAL_MIN);
    push_request(OP_CLEAR, 0, '0, 0, 0);
    random_phase(130);

    // new empty value without refill: stored nodes keep the old one
    quiesce();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(1'b1, pick_value());
    random_phase(70);
    quiesce();
    write_config(1'b0, '0);
    random_phase(70);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (i = 0; i < END_WAIT_MAX && pending != 0; i++) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (pending != 0) begin
      $display("%0t: %0d expected query results never arrived", $time, pending);
    end
    $display("Covered %0d sets, %0d queries, %0d clears, %0d ignored requests; %0d results.",
             n_set, n_query, n_clear, n_ignored, results_seen);
    $display("Both combine modes, empty value at default, extremes, zero and random.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
